### src/entity_unescape_stream_core_macros.svh
// Assertion macros for the entity unescape stream core.
// Used by entity_unescape_stream_core.sv in src; expects clk_i and rst_ni in scope.
`ifndef ENTITY_UNESCAPE_STREAM_CORE_MACROS_SVH
`define ENTITY_UNESCAPE_STREAM_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define EUS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("entity_unescape_stream_core: assertion failed");

// Next-cycle implication, disabled during reset
`define EUS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("entity_unescape_stream_core: assertion failed");

`endif

### src/eus_pkg.sv
// Package for the entity unescape stream core: payload types, entity table.
// No dependencies.
package eus_pkg;

  localparam int NumEntities = 7;
  localparam int HoldDepth   = 5;
  localparam int EntMaxLen   = 6;
  localparam int MaxResults  = 6;
  localparam int CntW        = 3;

  localparam logic [7:0] ChrAmp = 8'h26;  // '&'

  // Entity texts, zero padded past their length
  localparam logic [7:0] EntText [NumEntities][EntMaxLen] = '{
    '{8'h26, 8'h23, 8'h31, 8'h32, 8'h34, 8'h3B},  // &#124;
    '{8'h26, 8'h23, 8'h33, 8'h36, 8'h3B, 8'h00},  // &#36;
    '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},  // &amp;
    '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},  // &lt;
    '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},  // &gt;
    '{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},  // &apos;
    '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B}   // &quot;
  };

  localparam logic [CntW-1:0] EntLen [NumEntities] = '{
    3'd6, 3'd5, 3'd5, 3'd4, 3'd4, 3'd6, 3'd6
  };

  // Replacement characters: | $ & < > ' "
  localparam logic [7:0] EntRepl [NumEntities] = '{
    8'h7C, 8'h24, 8'h26, 8'h3C, 8'h3E, 8'h27, 8'h22
  };

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       run_last;
    logic       text_done;
  } out_item_t;

endpackage

### src/entity_unescape_stream_core.sv
// Top level of the entity unescape stream core: input register, matcher,
// result shift buffer. Depends on eus_pkg and entity_unescape_stream_core_macros.svh.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------
//   in      | input     | in_valid_i/in_ready_o  | eus_pkg::in_item_t
//   out     | output    | out_valid_o/out_ready_i| eus_pkg::out_item_t
//
// Each byte is held in the input register, then is matched and its results (0 to 6)
// load the result buffer, which drains one per cycle while the output is ready.
// Items with at most one result flow at one per cycle while the output is ready;
// an item with k results holds the input side until the single output port takes them.
// Reset clears the held count and both valid states; no clearing pass.
// A stalled output holds the buffer and, once the input register is full, the input.
`include "entity_unescape_stream_core_macros.svh"

module entity_unescape_stream_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  eus_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output eus_pkg::out_item_t  out_data_o
);
  import eus_pkg::*;

  // Input register
  logic     inq_valid_q;
  in_item_t inq_q;

  // Partial entity state
  logic [7:0]      held_q [HoldDepth];
  logic [CntW-1:0] held_cnt_q, held_cnt_d;

  // Result buffer, front entry is the one shown
  logic [7:0]      res_q [MaxResults];
  logic [7:0]      res_d [MaxResults];
  logic [CntW-1:0] rem_q, rcnt_d;
  logic            res_eot_q;

  logic load, take;

  assign take   = out_valid_o && out_ready_i;
  assign load   = inq_valid_q && ((rem_q == '0) || ((rem_q == CntW'(1)) && out_ready_i));
  assign in_ready_o = !inq_valid_q || load;

  // Matcher
  logic [CntW-1:0] hc, n;
  logic [7:0]      cand [EntMaxLen];
  logic            ok, full, prefix, amp_hold, eot;
  logic [7:0]      repl, b;

  always_comb begin
    b   = inq_q.byte_in;
    eot = inq_q.end_of_text;
    hc  = (held_cnt_q > CntW'(HoldDepth)) ? '0 : held_cnt_q;
    n   = hc + CntW'(1);

    // candidate = held bytes followed by the new byte
    for (int i = 0; i < EntMaxLen; i++) begin
      if (i < HoldDepth && CntW'(i) < hc) begin
        cand[i] = held_q[i];
      end else begin
        cand[i] = b;
      end
    end

    full   = 1'b0;
    prefix = 1'b0;
    repl   = '0;
    for (int e = 0; e < NumEntities; e++) begin
      ok = (n <= EntLen[e]);
      for (int i = 0; i < EntMaxLen; i++) begin
        if (CntW'(i) < n && cand[i] != EntText[e][i]) begin
          ok = 1'b0;
        end
      end
      if (ok && n == EntLen[e]) begin
        full = 1'b1;
        repl = EntRepl[e];
      end
      if (ok && n < EntLen[e]) begin
        prefix = 1'b1;
      end
    end

    amp_hold = !full && !prefix && (b == ChrAmp) && !eot;

    // results are the candidate bytes, except for a completed entity
    for (int i = 0; i < MaxResults; i++) begin
      res_d[i] = cand[i];
    end
    held_cnt_d = '0;
    if (full) begin
      res_d[0] = repl;
      rcnt_d   = CntW'(1);
    end else if (prefix) begin
      if (eot) begin
        rcnt_d = n;
      end else begin
        rcnt_d     = '0;
        held_cnt_d = n;
      end
    end else if (amp_hold) begin
      rcnt_d     = n - CntW'(1);
      held_cnt_d = CntW'(1);
    end else begin
      rcnt_d = n;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
      held_cnt_q  <= '0;
      rem_q       <= '0;
    end else begin
      if (in_ready_o) begin
        inq_valid_q <= in_valid_i;
      end
      if (load) begin
        held_cnt_q <= held_cnt_d;
        rem_q      <= rcnt_d;
      end else if (take) begin
        rem_q <= rem_q - CntW'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      inq_q <= in_data_i;
    end
    if (load) begin
      if (prefix && !eot) begin
        for (int i = 0; i < HoldDepth; i++) begin
          held_q[i] <= cand[i];
        end
      end else if (amp_hold) begin
        held_q[0] <= ChrAmp;
      end
      for (int i = 0; i < MaxResults; i++) begin
        res_q[i] <= res_d[i];
      end
      res_eot_q <= eot;
    end else if (take) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
    end
  end

  // Output transaction
  assign out_valid_o          = (rem_q != '0);
  assign out_data_o.char_out  = res_q[0];
  assign out_data_o.run_last  = (rem_q == CntW'(1));
  assign out_data_o.text_done = (rem_q == CntW'(1)) && res_eot_q;

  // Assertions
  `EUS_ASSERT_IMPL(a_held_cnt_range, 1'b1, held_cnt_q <= CntW'(HoldDepth))
  `EUS_ASSERT_IMPL(a_rem_range, 1'b1, rem_q <= CntW'(MaxResults))
  `EUS_ASSERT_IMPL(a_held_starts_amp, held_cnt_q != '0, held_q[0] == ChrAmp)
  `EUS_ASSERT_IMPL(a_load_when_free, load,
                   (rem_q == '0) || ((rem_q == CntW'(1)) && take))
  `EUS_ASSERT_NEXT(a_stall_holds, out_valid_o && !out_ready_i, rem_q == $past(rem_q))

endmodule
